[src/fwdds_pkg.sv]
package fwdds_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_PERCENT = 2'd2;

    // waveform selection codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd3;

    // register reset values
    localparam logic [1:0]  WAVE_MODE_RST  = WAVE_SINE;
    localparam logic [31:0] PHASE_STEP_RST = 32'd429497;
    localparam logic [6:0]  DUTY_RST       = 7'd50;

    // output code limits
    localparam logic [6:0] DUTY_MAX   = 7'd100;
    localparam logic [7:0] SAMPLE_MAX = 8'd255;

    // pi/2 in Q30 and one in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    // settings seen by the waveform logic
    typedef struct packed {
        logic [1:0] wave_mode;
        logic [6:0] duty_percent;
    } t_wave_cfg;

    // sine of k quarter steps in Q30, truncated Taylor series through x^15
    function automatic logic [63:0] quarter_sine(input int unsigned k,
                                                 input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        x    = (64'(k) * HALF_PI_Q30) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        acc  = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        acc  = acc + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        acc  = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        acc  = acc + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        acc  = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        acc  = acc + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        acc  = acc - longint'(term);
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(Q30_ONE)) begin
            acc = longint'(Q30_ONE);
        end
        return 64'(acc);
    endfunction

    // upper half code in [15:8], lower half code in [7:0] for quarter step k
    function automatic logic [15:0] sine_codes(input int unsigned k,
                                               input int unsigned qbits);
        logic [63:0] s;
        logic [63:0] up;
        logic [63:0] dn;
        s  = quarter_sine(k, qbits);
        up = ((Q30_ONE + s) * 64'd127) >> 30;
        dn = ((Q30_ONE - s) * 64'd127) >> 30;
        if (up > 64'd254) begin
            up = 64'd254;
        end
        return {up[7:0], dn[7:0]};
    endfunction

endpackage

[src/fwdds_wave.sv]
module fwdds_wave
    import fwdds_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic [PHASE_BITS-1:0] i_phase,
    input  t_wave_cfg             i_cfg,
    output logic [7:0]            o_sample
);

    localparam int QB      = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QB;
    localparam logic [QB:0] QUARTER_V = (QB + 1)'(QUARTER);

    // quarter-wave code table, built at elaboration
    logic [15:0] w_sine_tab [QUARTER];

    for (genvar g = 0; g < QUARTER; g++) begin : g_sine
        localparam logic [15:0] CODES = sine_codes(g, QB);
        assign w_sine_tab[g] = CODES;
    end

    // sine: fold the table index into the first quarter
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [1:0]                 w_quad;
    logic [QB:0]                w_k;
    logic [15:0]                w_codes;
    logic [7:0]                 w_sine;

    assign w_idx  = i_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign w_quad = w_idx[SINE_TABLE_BITS-1 -: 2];
    assign w_k    = w_quad[0] ? (QUARTER_V - {1'b0, w_idx[QB-1:0]})
                              : {1'b0, w_idx[QB-1:0]};

    always_comb begin
        // the quarter point itself is the crest or the trough
        if (w_k[QB]) begin
            w_codes = {8'd254, 8'd0};
        end else begin
            w_codes = w_sine_tab[w_k[QB-1:0]];
        end
        w_sine = w_quad[1] ? w_codes[7:0] : w_codes[15:8];
    end

    // square: phase * 100 against duty * full turn
    logic [6:0]            w_duty;
    logic [PHASE_BITS+6:0] w_p100;
    logic [PHASE_BITS+6:0] w_thresh;
    logic [7:0]            w_square;

    assign w_duty   = (i_cfg.duty_percent > DUTY_MAX) ? DUTY_MAX : i_cfg.duty_percent;
    assign w_p100   = {1'b0, i_phase, 6'b0} + {2'b0, i_phase, 5'b0}
                    + {5'b0, i_phase, 2'b0};
    assign w_thresh = {w_duty, {PHASE_BITS{1'b0}}};
    assign w_square = (w_p100 < w_thresh) ? SAMPLE_MAX : 8'd0;

    // triangle: offset within the half turn times 255
    logic [PHASE_BITS-2:0] w_half_off;
    logic [PHASE_BITS+6:0] w_tri_m;
    logic [PHASE_BITS+6:0] w_tri_up;
    logic [7:0]            w_tri;

    assign w_half_off = i_phase[PHASE_BITS-2:0];
    assign w_tri_m    = {w_half_off, 8'b0} - {8'b0, w_half_off};
    assign w_tri_up   = w_tri_m + {8'b0, {(PHASE_BITS-1){1'b1}}};
    assign w_tri      = i_phase[PHASE_BITS-1]
                      ? (SAMPLE_MAX - w_tri_up[PHASE_BITS+6:PHASE_BITS-1])
                      : w_tri_m[PHASE_BITS+6:PHASE_BITS-1];

    // sawtooth: top bits of phase times 255
    logic [PHASE_BITS+7:0] w_saw_m;

    assign w_saw_m = {i_phase, 8'b0} - {8'b0, i_phase};

    // waveform select
    always_comb begin
        case (i_cfg.wave_mode)
            WAVE_SINE:     o_sample = w_sine;
            WAVE_SQUARE:   o_sample = w_square;
            WAVE_TRIANGLE: o_sample = w_tri;
            WAVE_SAWTOOTH: o_sample = w_saw_m[PHASE_BITS+7:PHASE_BITS];
            default:       o_sample = w_sine;
        endcase
    end

endmodule

[src/four_wave_dds_generator.sv]
// pipeline: an accepted transaction passes the input register, then the result register
// throughput: one transaction per cycle unless i_out_stall holds a result, set by the
// single phase-add and waveform stages; an input is taken while a result waits if the
// input register is empty; reset: synchronous active low; clears phase, pipeline valids
// and restores wave_mode sine, phase_step 429497 and duty_percent 50
module four_wave_dds_generator
    import fwdds_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_restart,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_sample,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SUM_W = ((PHASE_BITS > 32) ? PHASE_BITS : 32) + 1;

    logic [1:0]            r_wave_mode;
    logic [31:0]           r_phase_step;
    logic [6:0]            r_duty;
    logic [PHASE_BITS-1:0] r_acc;
    logic                  r_s1_valid;
    logic [PHASE_BITS-1:0] r_s1_phase;
    logic                  r_out_valid;
    logic [7:0]            r_sample;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode  <= WAVE_MODE_RST;
            r_phase_step <= PHASE_STEP_RST;
            r_duty       <= DUTY_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WAVE_MODE:    r_wave_mode  <= i_cfg_data[1:0];
                CFG_PHASE_STEP:   r_phase_step <= i_cfg_data[31:0];
                CFG_DUTY_PERCENT: r_duty       <= i_cfg_data[6:0];
                default:          r_wave_mode  <= r_wave_mode;
            endcase
        end
    end

    // handshake control
    logic w_out_adv;
    logic w_in_acc;

    assign w_out_adv  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !w_out_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // phase for this transaction and the next accumulator value
    logic [PHASE_BITS-1:0] w_cur;
    logic [SUM_W-1:0]      w_sum;
    logic                  w_wrap;
    logic [PHASE_BITS-1:0] n_acc;

    assign w_cur  = i_restart ? '0 : r_acc;
    assign w_sum  = {{(SUM_W-PHASE_BITS){1'b0}}, w_cur}
                  + {{(SUM_W-32){1'b0}}, r_phase_step};
    assign w_wrap = |w_sum[SUM_W-1:PHASE_BITS];
    assign n_acc  = w_wrap ? '0 : w_sum[PHASE_BITS-1:0];

    // phase accumulator and input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_acc      <= n_acc;
            r_s1_valid <= 1'b1;
        end else if (w_out_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_phase <= w_cur;
        end
    end

    // waveform from the registered phase
    t_wave_cfg  w_cfg;
    logic [7:0] w_sample;

    assign w_cfg.wave_mode    = r_wave_mode;
    assign w_cfg.duty_percent = r_duty;

    fwdds_wave #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_wave (
        .i_phase  (r_s1_phase),
        .i_cfg    (w_cfg),
        .o_sample (w_sample)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_s1_valid) begin
            r_sample <= w_sample;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    // checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with an empty input register");

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_restart |=> r_s1_phase == '0)
        else $error("restart transaction did not start at phase zero");

    a_phase_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_restart |=> r_s1_phase == $past(r_acc))
        else $error("transaction phase does not follow the accumulator");

    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && w_out_adv |=> r_out_valid)
        else $error("transaction lost between input and result registers");

endmodule
